// ===== hdl/mobius_liouville_running_sums_top_macros.svh =====
// assertion macros for the mobius / liouville running sums block
// used by the port checker; relies on clk_i and rst_ni in scope
`ifndef MOBIUS_LIOUVILLE_RUNNING_SUMS_TOP_MACROS_SVH
`define MOBIUS_LIOUVILLE_RUNNING_SUMS_TOP_MACROS_SVH

// plain clocked property, held off during reset
`define MLRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition now implies consequence on the next clock
`define MLRS_ASSERT_NEXT(lbl, pre, post, msg) \
  `MLRS_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== hdl/mlrs_pkg.sv =====
// shared constants, command/status types for the mobius / liouville block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mlrs_pkg;

  localparam int NUMBER_WIDTH_DEF = 24;
  localparam int THR_W = 16;
  localparam int ACC_W = 25;
  localparam int MU_W = 2;
  localparam int CNT_OUT_W = 5;
  localparam int OUT_W = 64;
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int LHS_SHIFT = 24;
  localparam int LHS_W = 72;

  localparam logic [CNT_OUT_W-1:0] CNT_MAX = 5'd31;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MERTENS_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIOUVILLE_THR = 1'b1;

  localparam logic [THR_W-1:0] MERTENS_THR_RST = 16'd2048;
  localparam logic [THR_W-1:0] LIOUVILLE_THR_RST = 16'd4096;

  // mobius value codes
  localparam logic [MU_W-1:0] MU_ZERO = 2'b00;
  localparam logic [MU_W-1:0] MU_PLUS = 2'b01;
  localparam logic [MU_W-1:0] MU_MINUS = 2'b11;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_THR_SQ,
    MUL_MAG_SQ,
    MUL_T2_NLO,
    MUL_T2_NHI
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    div_start;
    logic    div_step;
    logic    take_factor;
    logic    next_cand;
    logic    tail;
    logic    acc_update;
    mul_op_e mul_op;
    logic    sum_sel;
    logic    cmp;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic cand_ok;
    logic div_done;
    logic rem_zero;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/mobius_liouville_running_sums_top.sv =====
// top level of the mobius / liouville running sums block; uses mlrs_pkg, mlrs_ctrl, mlrs_datapath
// each trial candidate p with p*p <= remaining cofactor costs one bit-serial division,
//   each prime factor found costs one more, followed by the sums and the two breach tests
// one number is processed at a time, paced by the bit-serial remainder unit
// reset (rst_ni low, async): sums cleared, thresholds to 0.5 and 1.0, no beat pending
`timescale 1ns / 1ps
`default_nettype none

module mobius_liouville_running_sums_top
  import mlrs_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes, index 0 mertens threshold, 1 liouville threshold
  input  logic                                cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [THR_W-1:0]                    cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // number, zero pad
  input  logic                                s_axis_tuser,  // restart
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // mobius_value[1:0], factor_count[6:2], mertens_total[31:7],
  // liouville_total[56:32], mertens_breach[57], liouville_breach[58], zero pad
  output logic [OUT_W-1:0]                    m_axis_tdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic [MU_W-1:0]         mobius_value;
  logic [CNT_OUT_W-1:0]    factor_count;
  logic signed [ACC_W-1:0] mertens_total;
  logic signed [ACC_W-1:0] liouville_total;
  logic                    mertens_breach;
  logic                    liouville_breach;

  // sequencer: one number in flight, result held in the output register
  // so the next number can be taken while the last result waits
  mlrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // trial divider, sums and the exact breach comparison
  mlrs_datapath #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .number_i           (s_axis_tdata[NUMBER_WIDTH-1:0]),
    .restart_i          (s_axis_tuser),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .mobius_value_o     (mobius_value),
    .factor_count_o     (factor_count),
    .mertens_total_o    (mertens_total),
    .liouville_total_o  (liouville_total),
    .mertens_breach_o   (mertens_breach),
    .liouville_breach_o (liouville_breach)
  );

  // pack the result fields, lowest field first
  assign m_axis_tdata = OUT_W'({liouville_breach, mertens_breach, liouville_total,
                                mertens_total, factor_count, mobius_value});

endmodule

`default_nettype wire

// ===== hdl/mlrs_ctrl.sv =====
// controller state machine: trial division sequence, breach test steps, handshakes
// depends on mlrs_pkg for the command and status types
`timescale 1ns / 1ps
`default_nettype none

module mlrs_ctrl
  import mlrs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  output logic    s_tready_o,
  output logic    m_tvalid_o,
  input  logic    m_tready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_REDIV,
    S_TAIL,
    S_ACC,
    S_THR,
    S_MAG,
    S_NLO,
    S_NHI,
    S_SUM,
    S_CMP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   sel_q, sel_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.sum_sel = sel_q;
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.cand_ok) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_TAIL;
        end
      end
      S_DIV: begin
        if (!sts_i.div_done) begin
          cmd_o.div_step = 1'b1;
        end else if (sts_i.rem_zero) begin
          cmd_o.take_factor = 1'b1;
          state_d = S_REDIV;
        end else begin
          cmd_o.next_cand = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_REDIV: begin
        // same candidate again on the reduced value
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_update = 1'b1;
        sel_d = 1'b0;
        state_d = S_THR;
      end
      S_THR: begin
        cmd_o.mul_op = MUL_THR_SQ;
        state_d = S_MAG;
      end
      S_MAG: begin
        cmd_o.mul_op = MUL_MAG_SQ;
        state_d = S_NLO;
      end
      S_NLO: begin
        cmd_o.mul_op = MUL_T2_NLO;
        state_d = S_NHI;
      end
      S_NHI: begin
        cmd_o.mul_op = MUL_T2_NHI;
        state_d = S_SUM;
      end
      S_SUM: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (sel_q) begin
          state_d = S_DONE;
        end else begin
          sel_d = 1'b1;
          state_d = S_THR;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/mlrs_datapath.sv =====
// datapath: trial divider, factor bookkeeping, running sums, breach multiplier, output regs
// depends on mlrs_pkg; driven by mlrs_ctrl through dp_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module mlrs_datapath
  import mlrs_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [THR_W-1:0]              cfg_data_i,
  input  logic [NUMBER_WIDTH-1:0]       number_i,
  input  logic                          restart_i,
  input  dp_cmd_t                       cmd_i,
  output dp_sts_t                       sts_o,
  output logic [MU_W-1:0]               mobius_value_o,
  output logic [CNT_OUT_W-1:0]          factor_count_o,
  output logic signed [ACC_W-1:0]       mertens_total_o,
  output logic signed [ACC_W-1:0]       liouville_total_o,
  output logic                          mertens_breach_o,
  output logic                          liouville_breach_o
);

  localparam int NW  = NUMBER_WIDTH;
  localparam int PW  = (NW + 1) / 2 + 1;
  localparam int QW  = NW + 1;
  localparam int CW  = $clog2(NW + 1);
  localparam int DCW = $clog2(NW + 1);
  localparam int NLO = (NW + 1) / 2;
  localparam int NHI = NW - NLO;
  localparam int RW  = MUL_A_W + NW;
  localparam logic signed [ACC_W:0] SUM_MAX = (ACC_W + 1)'((1 << (ACC_W - 1)) - 1);
  localparam logic signed [ACC_W:0] SUM_MIN = -SUM_MAX;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [MU_W-1:0]  d
  );
    logic signed [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + {{(ACC_W - 1){d[MU_W-1]}}, d};
    if (s > SUM_MAX) begin
      s = SUM_MAX;
    end else if (s < SUM_MIN) begin
      s = SUM_MIN;
    end
    return s[ACC_W-1:0];
  endfunction

  // configuration and accumulators
  logic [THR_W-1:0]        mthr_q, lthr_q;
  logic signed [ACC_W-1:0] macc_q, lacc_q;
  logic [DCW-1:0]          div_cnt_q;
  mul_op_e                 mul_op_q;

  // working registers
  logic [NW-1:0]       n_q, m_q, dvd_q;
  logic                restart_q;
  logic [PW-1:0]       p_q, rem_q;
  logic [QW-1:0]       psq_q;
  logic [CW-1:0]       count_q;
  logic                dist_par_q, square_q, e_one_q;
  logic [PROD_W-1:0]   prod_q;
  logic [MUL_A_W-1:0]  t2_q;
  logic [LHS_W-1:0]    lhs_q;
  logic [RW-1:0]       rhs_q;
  logic                mbr_q, lbr_q;

  // output registers
  logic [MU_W-1:0]         mu_out_q;
  logic [CNT_OUT_W-1:0]    cnt_out_q;
  logic signed [ACC_W-1:0] macc_out_q, lacc_out_q;
  logic                    mbr_out_q, lbr_out_q;

  // divider step
  logic [PW:0]   trial;
  logic          ge;
  logic [PW-1:0] rem_next;
  assign trial    = {rem_q, dvd_q[NW-1]};
  assign ge       = trial >= (PW + 1)'(p_q);
  assign rem_next = ge ? PW'(trial - (PW + 1)'(p_q)) : PW'(trial);

  // factor outcome
  logic [MU_W-1:0]    mu;
  logic [MU_W-1:0]    lam;
  logic [CW+4:0]      cnt_x;
  logic [CNT_OUT_W-1:0] cnt_sat;
  assign mu      = square_q ? MU_ZERO : (dist_par_q ? MU_MINUS : MU_PLUS);
  assign lam     = count_q[0] ? MU_MINUS : MU_PLUS;
  assign cnt_x   = (CW + 5)'(count_q);
  assign cnt_sat = (cnt_x > (CW + 5)'(CNT_MAX)) ? CNT_MAX : cnt_x[CNT_OUT_W-1:0];

  // multiplier operands
  logic signed [ACC_W-1:0] sum_sel;
  logic [ACC_W-1:0]        mag_full;
  logic [MUL_B_W-1:0]      mag;
  logic [THR_W-1:0]        thr_sel;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  assign sum_sel  = cmd_i.sum_sel ? lacc_q : macc_q;
  assign mag_full = sum_sel[ACC_W-1] ? ACC_W'(-sum_sel) : ACC_W'(sum_sel);
  assign mag      = mag_full[MUL_B_W-1:0];
  assign thr_sel  = cmd_i.sum_sel ? lthr_q : mthr_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MUL_THR_SQ: begin
        mul_a = MUL_A_W'(thr_sel);
        mul_b = MUL_B_W'(thr_sel);
      end
      MUL_MAG_SQ: begin
        mul_a = MUL_A_W'(mag);
        mul_b = mag;
      end
      MUL_T2_NLO: begin
        mul_a = t2_q;
        mul_b = MUL_B_W'(n_q[NLO-1:0]);
      end
      MUL_T2_NHI: begin
        mul_a = t2_q;
        mul_b = MUL_B_W'(n_q[NW-1:NLO]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic breach_now;
  assign breach_now = lhs_q > LHS_W'(rhs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mthr_q    <= MERTENS_THR_RST;
      lthr_q    <= LIOUVILLE_THR_RST;
      macc_q    <= '0;
      lacc_q    <= '0;
      div_cnt_q <= '0;
      mul_op_q  <= MUL_NONE;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MERTENS_THR:   mthr_q <= cfg_data_i;
          REG_LIOUVILLE_THR: lthr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.acc_update) begin
        macc_q <= sat_add(restart_q ? '0 : macc_q, mu);
        lacc_q <= sat_add(restart_q ? '0 : lacc_q, lam);
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= DCW'(NW);
      end else if (cmd_i.div_step && (div_cnt_q != '0)) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      mul_op_q <= cmd_i.mul_op;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q        <= number_i;
      m_q        <= number_i;
      restart_q  <= restart_i;
      p_q        <= PW'(2);
      psq_q      <= QW'(4);
      count_q    <= '0;
      dist_par_q <= 1'b0;
      square_q   <= 1'b0;
      e_one_q    <= 1'b0;
    end
    if (cmd_i.div_start) begin
      dvd_q <= m_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[NW-2:0], ge};
      rem_q <= rem_next;
    end
    if (cmd_i.take_factor) begin
      m_q     <= dvd_q;
      count_q <= count_q + 1'b1;
      e_one_q <= 1'b1;
      if (e_one_q) begin
        square_q <= 1'b1;
      end else begin
        dist_par_q <= ~dist_par_q;
      end
    end
    if (cmd_i.next_cand) begin
      p_q     <= p_q + 1'b1;
      psq_q   <= psq_q + QW'({p_q, 1'b1});
      e_one_q <= 1'b0;
    end
    if (cmd_i.tail && (m_q > NW'(1))) begin
      count_q    <= count_q + 1'b1;
      dist_par_q <= ~dist_par_q;
    end
    // product register, then hand the product on in the next cycle
    prod_q <= PROD_W'(mul_a * mul_b);
    case (mul_op_q)
      MUL_THR_SQ: t2_q  <= prod_q[MUL_A_W-1:0];
      MUL_MAG_SQ: lhs_q <= LHS_W'(prod_q) << LHS_SHIFT;
      MUL_T2_NLO: rhs_q <= RW'(prod_q);
      MUL_T2_NHI: rhs_q <= rhs_q + (RW'(prod_q) << NLO);
      default: ;
    endcase
    if (cmd_i.cmp) begin
      if (cmd_i.sum_sel) begin
        lbr_q <= breach_now;
      end else begin
        mbr_q <= breach_now;
      end
    end
    if (cmd_i.load_out) begin
      mu_out_q   <= mu;
      cnt_out_q  <= cnt_sat;
      macc_out_q <= macc_q;
      lacc_out_q <= lacc_q;
      mbr_out_q  <= mbr_q;
      lbr_out_q  <= lbr_q;
    end
  end

  assign sts_o.cand_ok  = psq_q <= QW'(m_q);
  assign sts_o.div_done = (div_cnt_q == '0);
  assign sts_o.rem_zero = (rem_q == '0);

  assign mobius_value_o     = mu_out_q;
  assign factor_count_o     = cnt_out_q;
  assign mertens_total_o    = macc_out_q;
  assign liouville_total_o  = lacc_out_q;
  assign mertens_breach_o   = mbr_out_q;
  assign liouville_breach_o = lbr_out_q;

endmodule

`default_nettype wire

// ===== hdl/mlrs_checker.sv =====
// port checker for the mobius / liouville block, bound to the top level
// depends on mlrs_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "mobius_liouville_running_sums_top_macros.svh"

module mlrs_checker
  import mlrs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // a stalled result must not change
  `MLRS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

  // one number at a time: no second beat straight after an accepted one
  `MLRS_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

  // a square factor needs at least two prime factors
  `MLRS_ASSERT(a_mu_zero_count, (m_axis_tvalid && (m_axis_tdata[1:0] == MU_ZERO)) |-> (m_axis_tdata[6:2] >= 5'd2), "zero mobius with too few factors")

  // squarefree: sign of mobius follows parity of the factor count
  `MLRS_ASSERT(a_mu_parity, (m_axis_tvalid && (m_axis_tdata[1:0] != MU_ZERO)) |-> ((m_axis_tdata[1:0] == MU_MINUS) == m_axis_tdata[2]), "mobius sign and factor parity disagree")

endmodule

bind mobius_liouville_running_sums_top mlrs_checker u_mlrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
